FILE: rtl/assert_macros.svh
// Shared assertion helpers for the CRC engine checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mwcrc_pkg.sv
package mwcrc_pkg;

    localparam int CRC_W     = 64;
    localparam int CFG_IDX_W = 2;

    // CRC forms held in the form register
    localparam logic [1:0] FORM_CRC8  = 2'd0;
    localparam logic [1:0] FORM_CRC16 = 2'd1;
    localparam logic [1:0] FORM_CRC32 = 2'd2;
    localparam logic [1:0] FORM_CRC64 = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FORM      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL     = 2'd3;

    localparam logic [1:0]       RST_FORM      = FORM_CRC8;
    localparam logic [CRC_W-1:0] RST_GENERATOR = 64'h1D;
    localparam logic [CRC_W-1:0] RST_START     = 64'hFF;
    localparam logic [CRC_W-1:0] RST_FINAL     = 64'hFF;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             call_begin;
        logic             first_call;
        logic [CRC_W-1:0] resume_value;
        logic             call_end;
        logic             empty_call;
    } crc_item_t;

    typedef struct packed {
        logic [1:0]       form;
        logic [CRC_W-1:0] generator;
        logic [CRC_W-1:0] start_constant;
        logic [CRC_W-1:0] final_xor;
    } crc_cfg_t;

    function automatic logic [CRC_W-1:0] form_mask(input logic [1:0] form);
        logic [CRC_W-1:0] m;
        unique case (form)
            FORM_CRC8:  m = 64'h0000_0000_0000_00FF;
            FORM_CRC16: m = 64'h0000_0000_0000_FFFF;
            FORM_CRC32: m = 64'h0000_0000_FFFF_FFFF;
            FORM_CRC64: m = 64'hFFFF_FFFF_FFFF_FFFF;
            default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/mwcrc_fold.sv
// Load the register when a call begins, fold in the byte unless the request is empty, and form the call result.
module mwcrc_fold (
    input  mwcrc_pkg::crc_cfg_t          cfg,
    input  mwcrc_pkg::crc_item_t         item,
    input  logic [mwcrc_pkg::CRC_W-1:0]  running_crc,
    output logic [mwcrc_pkg::CRC_W-1:0]  crc_next,
    output logic [mwcrc_pkg::CRC_W-1:0]  crc_result
);
    import mwcrc_pkg::*;

    logic [CRC_W-1:0] mask;
    logic [CRC_W-1:0] fin;
    logic [CRC_W-1:0] poly;
    logic [CRC_W-1:0] crc;
    logic             reflected;
    logic             fb;

    always_comb begin
        mask      = form_mask(cfg.form);
        fin       = cfg.final_xor & mask;
        poly      = cfg.generator & mask;
        reflected = (cfg.form == FORM_CRC32) || (cfg.form == FORM_CRC64);
        fb        = 1'b0;

        crc = running_crc & mask;
        if (item.call_begin) begin
            if (item.first_call) begin
                crc = cfg.start_constant & mask;
            end else begin
                crc = (item.resume_value ^ fin) & mask;
            end
        end

        if (!item.empty_call) begin
            // inject the byte at the end the shift reads from
            if (reflected) begin
                crc[7:0] = crc[7:0] ^ item.data_byte;
            end else if (cfg.form == FORM_CRC8) begin
                crc[7:0] = crc[7:0] ^ item.data_byte;
            end else begin
                crc[15:8] = crc[15:8] ^ item.data_byte;
            end

            for (int i = 0; i < 8; i++) begin
                if (reflected) begin
                    fb  = crc[0];
                    crc = (crc >> 1) ^ (fb ? poly : '0);
                end else begin
                    fb  = (cfg.form == FORM_CRC8) ? crc[7] : crc[15];
                    crc = ((crc << 1) ^ (fb ? poly : '0)) & mask;
                end
            end
        end

        crc_next   = crc & mask;
        crc_result = (crc ^ fin) & mask;
    end

endmodule

FILE: rtl/multi_width_crc_engine.sv
// Byte-stream CRC engine for 8-bit and 16-bit MSB-first and 32-bit and 64-bit
// reflected CRCs, with polynomial, start value and final XOR set through the
// configuration port. Each input request carries one data byte; tuser marks the
// first request of a call, whether it starts fresh or resumes from a previous
// result, and whether the request carries no byte at all; tlast closes the
// call and makes the engine deliver one result, the CRC XOR the final value,
// zero-extended to 64 bits. The engine takes one byte every cycle unless a
// request that closes a call waits for the result slot: a request is held in
// the input register, the eight-step fold network between that register and
// the result register folds it, and the result register drives m_tdata. A
// result that waits on m_tready holds only requests that close a call; bytes
// without tlast keep flowing. Write configuration only while no request is in
// flight.
module multi_width_crc_engine (
    input  logic                              aclk,
    input  logic                              aresetn,

    // configuration write port
    input  logic                              cfg_we,
    input  logic [mwcrc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mwcrc_pkg::CRC_W-1:0]       cfg_wdata,

    // input request channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [71:0]                       s_tdata,  // [7:0] data_byte, [71:8] resume_value
    input  logic [2:0]                        s_tuser,  // [0] call_begin, [1] first_call,
                                                        // [2] empty_call
    input  logic                              s_tlast,  // call_end

    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [63:0]                       m_tdata   // [63:0] crc_value
);
    import mwcrc_pkg::*;

    // configuration registers
    crc_cfg_t         cfg_reg;

    // input stage
    logic             a_valid_reg, a_valid_next;
    crc_item_t        a_item_reg;

    // running CRC and result stage
    logic [CRC_W-1:0] running_crc_reg, running_crc_next;
    logic             m_valid_reg, m_valid_next;
    logic [CRC_W-1:0] m_data_reg;

    logic [CRC_W-1:0] fold_crc;
    logic [CRC_W-1:0] fold_result;
    logic             out_free;
    logic             a_advance;
    logic             s_accept;

    // Only a request that closes a call needs the result slot free.
    assign out_free  = !m_valid_reg || m_tready;
    assign a_advance = a_valid_reg && (!a_item_reg.call_end || out_free);
    assign s_tready  = !a_valid_reg || a_advance;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    mwcrc_fold u_fold (
        .cfg         (cfg_reg),
        .item        (a_item_reg),
        .running_crc (running_crc_reg),
        .crc_next    (fold_crc),
        .crc_result  (fold_result)
    );

    always_comb begin
        a_valid_next = a_valid_reg;
        if (s_accept) begin
            a_valid_next = 1'b1;
        end else if (a_advance) begin
            a_valid_next = 1'b0;
        end
    end

    always_comb begin
        running_crc_next = running_crc_reg;
        m_valid_next     = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (a_advance) begin
            running_crc_next = fold_crc;
            if (a_item_reg.call_end) begin
                m_valid_next = 1'b1;
            end
        end
    end

    // Hold configuration; the form register keeps only its two bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.form           <= RST_FORM;
            cfg_reg.generator      <= RST_GENERATOR;
            cfg_reg.start_constant <= RST_START;
            cfg_reg.final_xor      <= RST_FINAL;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_FORM:      cfg_reg.form           <= cfg_wdata[1:0];
                CFG_GENERATOR: cfg_reg.generator      <= cfg_wdata;
                CFG_START:     cfg_reg.start_constant <= cfg_wdata;
                CFG_FINAL:     cfg_reg.final_xor      <= cfg_wdata;
                default:       cfg_reg                <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            running_crc_reg <= '0;
        end else begin
            a_valid_reg     <= a_valid_next;
            m_valid_reg     <= m_valid_next;
            running_crc_reg <= running_crc_next;
        end
    end

    // Payload: load a new request, capture the result when a call closes.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_item_reg.data_byte    <= s_tdata[7:0];
            a_item_reg.resume_value <= s_tdata[71:8];
            a_item_reg.call_begin   <= s_tuser[0];
            a_item_reg.first_call   <= s_tuser[1];
            a_item_reg.empty_call   <= s_tuser[2];
            a_item_reg.call_end     <= s_tlast;
        end
        if (a_advance && a_item_reg.call_end) begin
            m_data_reg <= fold_result;
        end
    end

endmodule

FILE: rtl/mwcrc_checker.sv
`include "assert_macros.svh"

module mwcrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // a stalled result holds its value
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // with the result slot free the input never backs up
    `ASSERT_IMP(a_in_free, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled with a free result slot")

    // a new result comes from a request with tlast taken earlier, through the input and result registers
    `ASSERT_IMP(a_out_src, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast, 2), "result without a closing request")

endmodule

bind multi_width_crc_engine mwcrc_checker u_mwcrc_checker (.*);

FILE: tb/mwcrc_result_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both stream channels, keeps its own CRC
// state and compares every delivered result with the oldest expected CRC.
module mwcrc_result_checker
    import mwcrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CRC_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [71:0]          s_tdata,   // [7:0] data_byte, [71:8] resume_value
    input  logic [2:0]           s_tuser,   // [0] call_begin, [1] first_call, [2] empty_call
    input  logic                 s_tlast,   // call_end
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [63:0]          m_tdata,   // [63:0] crc_value
    output int                   mismatches,
    output int                   outstanding
);

    logic [1:0]       form_q;
    logic [CRC_W-1:0] poly_q;
    logic [CRC_W-1:0] start_q;
    logic [CRC_W-1:0] final_q;
    logic [CRC_W-1:0] crc_q;
    logic [CRC_W-1:0] expected_crc [$];

    function automatic logic [CRC_W-1:0] width_mask(input logic [1:0] form);
        case (form)
            FORM_CRC8:  return 64'h0000_0000_0000_00FF;
            FORM_CRC16: return 64'h0000_0000_0000_FFFF;
            FORM_CRC32: return 64'h0000_0000_FFFF_FFFF;
            default:    return 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    // Fold one byte into the register, bit-serial.
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [1:0]       form,
                                                  input logic [CRC_W-1:0] poly,
                                                  input logic [7:0]       data);
        logic [CRC_W-1:0] mask;
        logic [CRC_W-1:0] p;
        logic [CRC_W-1:0] r;
        int               w;
        int               i;
        mask = width_mask(form);
        p    = poly & mask;
        r    = crc & mask;
        if (form == FORM_CRC32 || form == FORM_CRC64) begin
            r = r ^ {56'd0, data};
            for (i = 0; i < 8; i++) begin
                r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
            end
        end else begin
            w = (form == FORM_CRC16) ? 16 : 8;
            r = r ^ ({56'd0, data} << (w - 8));
            for (i = 0; i < 8; i++) begin
                r = r[w-1] ? (((r << 1) ^ p) & mask) : ((r << 1) & mask);
            end
        end
        return r & mask;
    endfunction

    always @(posedge aclk) begin : watch
        crc_item_t        req;
        logic [CRC_W-1:0] mask;
        logic [CRC_W-1:0] fin;
        logic [CRC_W-1:0] r;
        logic [CRC_W-1:0] want;
        if (!aresetn) begin
            form_q     = RST_FORM;
            poly_q     = RST_GENERATOR;
            start_q    = RST_START;
            final_q    = RST_FINAL;
            crc_q      = '0;
            mismatches = 0;
            expected_crc.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_FORM:      form_q  = cfg_wdata[1:0];
                    CFG_GENERATOR: poly_q  = cfg_wdata;
                    CFG_START:     start_q = cfg_wdata;
                    CFG_FINAL:     final_q = cfg_wdata;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (expected_crc.size() == 0) begin
                    $error("crc_value: result with no request pending, got %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_crc.pop_front();
                    if (m_tdata !== want) begin
                        $error("crc_value mismatch: expected %h, actual %h", want, m_tdata);
                        mismatches++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                req.data_byte    = s_tdata[7:0];
                req.resume_value = s_tdata[71:8];
                req.call_begin   = s_tuser[0];
                req.first_call   = s_tuser[1];
                req.empty_call   = s_tuser[2];
                req.call_end     = s_tlast;
                mask = width_mask(form_q);
                fin  = final_q & mask;
                r    = crc_q & mask;
                if (req.call_begin) begin
                    r = req.first_call ? (start_q & mask) : ((req.resume_value ^ fin) & mask);
                end
                if (!req.empty_call) begin
                    r = crc_fold(r, form_q, poly_q, req.data_byte);
                end
                crc_q = r;
                if (req.call_end) begin
                    expected_crc.push_back((r ^ fin) & mask);
                end
            end
        end
        outstanding = expected_crc.size();
    end

endmodule

FILE: tb/multi_width_crc_engine_tb.sv
`timescale 1ns / 1ps

module multi_width_crc_engine_tb;
    import mwcrc_pkg::*;

    localparam int NUM_PHASES     = 12;
    localparam int CALLS_PER_SET  = 112;  // random requests per configuration
    localparam int IDLE_LIMIT     = 2000; // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES   = 4;    // margin beyond the input and result registers

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_FORM;
    logic [CRC_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [71:0]          s_tdata   = '0;  // [7:0] data_byte, [71:8] resume_value
    logic [2:0]           s_tuser   = '0;  // [0] call_begin, [1] first_call, [2] empty_call
    logic                 s_tlast   = 1'b0; // call_end
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;         // [63:0] crc_value

    int mismatches;
    int outstanding;
    int burst_left = 0;
    int idle_cycles = 0;

    always #4 aclk = ~aclk;

    multi_width_crc_engine u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mwcrc_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Receiver back-pressure: alternate between runs of steady ready, hard
    // stalls and per-cycle coin flips, each run of random length.
    int rx_mode = 0;
    int rx_run  = 0;
    always @(negedge aclk) begin
        if (rx_run == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_run  = (rx_mode == 1) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end else begin
            rx_run--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'b0;
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Watchdog: count cycles in which neither channel completes a handshake.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("multi_width_crc_engine test failed");
            $finish;
        end
    end

    // 64-bit value that lands on the extremes now and then.
    function automatic logic [CRC_W-1:0] wide_random();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic crc_item_t make_request(input logic       call_begin,
                                               input logic       first_call,
                                               input logic [63:0] resume_value,
                                               input logic       call_end,
                                               input logic       empty_call,
                                               input logic [7:0] data_byte);
        crc_item_t it;
        it.call_begin   = call_begin;
        it.first_call   = first_call;
        it.resume_value = resume_value;
        it.call_end     = call_end;
        it.empty_call   = empty_call;
        it.data_byte    = data_byte;
        return it;
    endfunction

    // Present one request at the falling edge and hold it until it is taken.
    // Keep tvalid high through a burst; drop it for a random gap between bursts.
    task automatic send_request(input crc_item_t it);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.resume_value, it.data_byte};
        s_tuser  <= {it.empty_call, it.first_call, it.call_begin};
        s_tlast  <= it.call_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap        = $urandom_range(1, 10);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Drop tvalid, wait for every expected result, then let the pipeline drain
    // of requests that close no call.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Hold cfg_we high across back-to-back writes; cfg_release closes the run.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic cfg_release();
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_crc(input logic [1:0] form, input logic [CRC_W-1:0] poly,
                               input logic [CRC_W-1:0] start, input logic [CRC_W-1:0] fin);
        settle();
        cfg_write(CFG_FORM, {62'd0, form});
        cfg_write(CFG_GENERATOR, poly);
        cfg_write(CFG_START, start);
        cfg_write(CFG_FINAL, fin);
        cfg_release();
    endtask

    // Mostly well-formed calls with random content, plus empty calls and
    // requests with every field random (open calls, stray first_call, ...).
    task automatic run_calls(input int count);
        int sent;
        int len;
        int kind;
        int i;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 99);
            if (kind < 8) begin
                send_request(make_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                          wide_random(), 1'($urandom_range(0, 1)),
                                          1'($urandom_range(0, 1)),
                                          8'($urandom_range(0, 255))));
                sent++;
            end else if (kind < 14) begin
                send_request(make_request(1'b1, 1'($urandom_range(0, 1)), wide_random(),
                                          1'b1, 1'b1, 8'($urandom_range(0, 255))));
                sent++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                for (i = 0; i < len; i++) begin
                    send_request(make_request(i == 0, 1'($urandom_range(0, 1)), wide_random(),
                                              i == len - 1, $urandom_range(0, 15) == 0,
                                              8'($urandom_range(0, 255))));
                end
                sent += len;
            end
        end
    endtask

    initial begin : stimulus
        int phase;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part on the reset configuration (8-bit, 0x1D, 0xFF, 0xFF).
        // Continue from the cleared register right after reset.
        send_request(make_request(1'b0, 1'b0, '1, 1'b1, 1'b0, 8'hFF));
        // Zero-length first call: byte ignored.
        send_request(make_request(1'b1, 1'b1, '0, 1'b1, 1'b1, 8'hA5));
        // first_call without call_begin has no effect.
        send_request(make_request(1'b0, 1'b1, '0, 1'b0, 1'b0, 8'h80));
        // Fresh call with an empty request in the middle.
        send_request(make_request(1'b1, 1'b1, '0, 1'b0, 1'b0, 8'h00));
        send_request(make_request(1'b0, 1'b0, '1, 1'b0, 1'b1, 8'h3C));
        send_request(make_request(1'b0, 1'b0, '0, 1'b1, 1'b0, 8'hFF));
        // Resume from the extremes, with and without data.
        send_request(make_request(1'b1, 1'b0, '1, 1'b1, 1'b0, 8'h55));
        send_request(make_request(1'b1, 1'b0, '0, 1'b1, 1'b1, 8'h01));
        // Open a call, then widen and later narrow the form in mid call.
        send_request(make_request(1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 8'h01));
        settle();
        cfg_write(CFG_FORM, {62'd0, FORM_CRC64});
        cfg_release();
        send_request(make_request(1'b0, 1'b0, '0, 1'b0, 1'b0, 8'hFE));
        settle();
        cfg_write(CFG_FORM, {62'd0, FORM_CRC16});
        cfg_release();
        send_request(make_request(1'b0, 1'b0, '0, 1'b1, 1'b0, 8'h7F));

        // Random part: one batch of calls per configuration.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:  program_crc(FORM_CRC8, 64'h1D, 64'hFF, 64'hFF);
                1:  program_crc(FORM_CRC16, 64'h1021, 64'hFFFF, 64'h0);
                2:  program_crc(FORM_CRC32, 64'hEDB8_8320, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
                3:  program_crc(FORM_CRC64, 64'hC96C_5795_D787_0F42, '1, '1);
                4:  program_crc(FORM_CRC8, 64'h2F, 64'hFF, 64'hFF);
                5:  program_crc(FORM_CRC32, 64'hC8DF_352F, 64'hFFFF_FFFF, 64'hFFFF_FFFF);
                6:  program_crc(FORM_CRC64, '0, '0, '0);
                7:  program_crc(FORM_CRC8, '1, '1, '1);
                8:  program_crc(FORM_CRC64, '1, '1, '1);
                9:  program_crc(FORM_CRC16, '1, '0, '1);
                default: program_crc(2'($urandom_range(0, 3)), {$urandom, $urandom},
                                     {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            run_calls(CALLS_PER_SET);
        end

        // Drain, then give the verdict.
        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("multi_width_crc_engine test passed");
        end else begin
            $display("multi_width_crc_engine test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/mwcrc_pkg.sv
rtl/mwcrc_fold.sv
rtl/multi_width_crc_engine.sv
rtl/mwcrc_checker.sv
tb/mwcrc_result_checker.sv
tb/multi_width_crc_engine_tb.sv
